// ----- hdl/gse_pkg.sv -----
// Shared types and constants for the grade statistics engine.
// Depends on nothing; imported by grade_statistics_engine.
`timescale 1ns / 1ps

package gse_pkg;

	localparam int SCORE_W = 7;
	localparam int COUNT_W = 11;
	localparam int SUM_W   = 17;
	localparam int DIV_W   = 27;

	typedef logic [1:0]         req_t;
	typedef logic [1:0]         status_t;
	typedef logic [SCORE_W-1:0] score_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [DIV_W-1:0]   div_t;

	localparam score_t SCORE_MAX       = 7'd100;
	localparam count_t MAX_SAMPLES     = 11'd1024;
	localparam score_t THRESHOLD_RESET = 7'd55;

	localparam logic [9:0]  MEAN_SCALE = 10'd1000;
	localparam logic [13:0] PASS_SCALE = 14'd10000;

	localparam req_t REQ_ADD   = 2'd0;
	localparam req_t REQ_SUM   = 2'd1;
	localparam req_t REQ_BIN   = 2'd2;
	localparam req_t REQ_CLEAR = 2'd3;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_RANGE = 2'd2;

endpackage

// ----- hdl/grade_statistics_engine.sv -----
// Top level of the grade statistics engine: count store, sequencer and shared divider.
// Depends on gse_pkg for types, request codes and status codes.
`timescale 1ns / 1ps

// Usage.
// A request word is taken when start is high and busy is low; req_type selects
// adding a sample, a summary, a histogram bin read or a clear. Each request gives
// exactly one result word, shown for a single cycle with done high. The receiver
// cannot stall, so results are never held back.
// The threshold register is written with cfg_wr_en and cfg_wr_data; the user must write
// it only while idle, as the block itself does not enforce this. A refused sample, a
// clear, a summary of an empty store or an out-of-range bin goes straight to the done
// state; an added sample passes a registered read and the write-back of one count,
// a bin read a registered read. A summary with samples walks all 101 counts through the
// store's single read port and then runs two 27-step divisions on one shared restoring
// divider. busy is low again in the done cycle, so the next request may be taken there.
// Reset clears all counts at once through per-entry valid bits, zeroes the
// totals, sets the minimum to 100 and the threshold to 55.
module grade_statistics_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gse_pkg::req_t     req_type,
	input  gse_pkg::score_t   sample,
	input  gse_pkg::score_t   bin_index,
	input  logic              cfg_wr_en,
	input  gse_pkg::score_t   cfg_wr_data,
	output logic              done,
	output gse_pkg::status_t  status,
	output gse_pkg::count_t   sample_total,
	output gse_pkg::score_t   min_value,
	output gse_pkg::score_t   max_value,
	output logic [16:0]       mean_milli,
	output gse_pkg::score_t   median_value,
	output logic [13:0]       pass_centi,
	output gse_pkg::count_t   bin_count
);
	import gse_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_ADD_RD   = 4'd1;
	localparam logic [3:0] S_ADD_WR   = 4'd2;
	localparam logic [3:0] S_BIN_RD   = 4'd3;
	localparam logic [3:0] S_BIN_WAIT = 4'd4;
	localparam logic [3:0] S_WALK     = 4'd5;
	localparam logic [3:0] S_WALK_END = 4'd6;
	localparam logic [3:0] S_MEAN_LD  = 4'd7;
	localparam logic [3:0] S_DIV      = 4'd8;
	localparam logic [3:0] S_PASS_LD  = 4'd9;
	localparam logic [3:0] S_FIN      = 4'd10;

	logic [3:0]            state_q;
	score_t                smp_q;
	score_t                bin_q;
	score_t                thr_q;
	count_t                count_q;
	sum_t                  sum_q;
	score_t                lo_q;
	score_t                hi_q;
	logic [SCORE_MAX:0]    valid_q;

	count_t                mem [0:SCORE_MAX];
	count_t                rd_data_q;
	logic                  rd_vld_q;
	score_t                rd_addr;
	logic                  mem_we;
	count_t                cnt_eff;

	score_t                walk_q;
	score_t                acc_addr_q;
	logic                  acc_vld_q;
	count_t                seen_q;
	count_t                passed_q;
	logic                  found_q;
	count_t                seen_nx;
	count_t                target;
	logic                  acc_en;

	div_t                  div_num_q;
	count_t                div_rem_q;
	logic [4:0]            div_cnt_q;
	logic                  div_sel_q;
	logic [COUNT_W:0]      rem_sh;
	logic                  div_ge;
	count_t                rem_nx;
	div_t                  num_nx;

	status_t               res_status_q;
	logic [16:0]           res_mean_q;
	score_t                res_median_q;
	logic [13:0]           res_pass_q;
	count_t                res_bin_q;

	logic                  done_q;
	status_t               status_q;
	count_t                total_q;
	score_t                min_q;
	score_t                max_q;
	logic [16:0]           mean_q;
	score_t                median_q;
	logic [13:0]           pass_q;
	count_t                bin_cnt_q;

	always_comb begin
		case (state_q)
			S_ADD_RD: rd_addr = smp_q;
			S_BIN_RD: rd_addr = score_t'(bin_q + 7'd1);
			S_WALK:   rd_addr = walk_q;
			default:  rd_addr = '0;
		endcase
	end

	assign mem_we  = (state_q == S_ADD_WR);
	assign cnt_eff = rd_vld_q ? rd_data_q : '0;
	assign seen_nx = count_t'(seen_q + cnt_eff);
	assign target  = count_t'(({1'b0, count_q} + 12'd1) >> 1);
	assign acc_en  = (state_q == S_WALK && acc_vld_q) || state_q == S_WALK_END;

	assign rem_sh = {div_rem_q, div_num_q[DIV_W-1]};
	assign div_ge = rem_sh >= {1'b0, count_q};
	assign rem_nx = div_ge ? count_t'(rem_sh - {1'b0, count_q}) : count_t'(rem_sh);
	assign num_nx = {div_num_q[DIV_W-2:0], div_ge};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[smp_q] <= count_t'(cnt_eff + 11'd1);
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			smp_q        <= '0;
			bin_q        <= '0;
			thr_q        <= THRESHOLD_RESET;
			count_q      <= '0;
			sum_q        <= '0;
			lo_q         <= SCORE_MAX;
			hi_q         <= '0;
			valid_q      <= '0;
			rd_vld_q     <= 1'b0;
			walk_q       <= '0;
			acc_addr_q   <= '0;
			acc_vld_q    <= 1'b0;
			seen_q       <= '0;
			passed_q     <= '0;
			found_q      <= 1'b0;
			div_num_q    <= '0;
			div_rem_q    <= '0;
			div_cnt_q    <= '0;
			div_sel_q    <= 1'b0;
			res_status_q <= ST_OK;
			res_mean_q   <= '0;
			res_median_q <= '0;
			res_pass_q   <= '0;
			res_bin_q    <= '0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			total_q      <= '0;
			min_q        <= '0;
			max_q        <= '0;
			mean_q       <= '0;
			median_q     <= '0;
			pass_q       <= '0;
			bin_cnt_q    <= '0;
		end else begin
			done_q   <= 1'b0;
			rd_vld_q <= valid_q[rd_addr];
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (acc_en) begin
				seen_q <= seen_nx;
				if (!found_q && seen_nx >= target) begin
					res_median_q <= acc_addr_q;
					found_q      <= 1'b1;
				end
				if (acc_addr_q >= thr_q) begin
					passed_q <= count_t'(passed_q + cnt_eff);
				end
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						smp_q        <= sample;
						bin_q        <= bin_index;
						res_status_q <= ST_OK;
						res_mean_q   <= '0;
						res_median_q <= '0;
						res_pass_q   <= '0;
						res_bin_q    <= '0;
						case (req_type)
							REQ_ADD: begin
								if (sample > SCORE_MAX) begin
									res_status_q <= ST_RANGE;
									state_q      <= S_FIN;
								end else if (count_q == MAX_SAMPLES) begin
									res_status_q <= ST_FULL;
									state_q      <= S_FIN;
								end else begin
									state_q <= S_ADD_RD;
								end
							end
							REQ_SUM: begin
								walk_q    <= '0;
								acc_vld_q <= 1'b0;
								seen_q    <= '0;
								passed_q  <= '0;
								found_q   <= 1'b0;
								state_q   <= (count_q == '0) ? S_FIN : S_WALK;
							end
							REQ_BIN: begin
								state_q <= (bin_index < SCORE_MAX) ? S_BIN_RD : S_FIN;
							end
							default: begin
								valid_q <= '0;
								count_q <= '0;
								sum_q   <= '0;
								lo_q    <= SCORE_MAX;
								hi_q    <= '0;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_ADD_RD: begin
					state_q <= S_ADD_WR;
				end
				S_ADD_WR: begin
					valid_q[smp_q] <= 1'b1;
					count_q        <= count_t'(count_q + 11'd1);
					sum_q          <= sum_t'(sum_q + sum_t'(smp_q));
					if (smp_q < lo_q) begin
						lo_q <= smp_q;
					end
					if (smp_q > hi_q) begin
						hi_q <= smp_q;
					end
					state_q <= S_FIN;
				end
				S_BIN_RD: begin
					state_q <= S_BIN_WAIT;
				end
				S_BIN_WAIT: begin
					res_bin_q <= cnt_eff;
					state_q   <= S_FIN;
				end
				S_WALK: begin
					acc_vld_q  <= 1'b1;
					acc_addr_q <= walk_q;
					walk_q     <= score_t'(walk_q + 7'd1);
					if (walk_q == SCORE_MAX) begin
						state_q <= S_WALK_END;
					end
				end
				S_WALK_END: begin
					state_q <= S_MEAN_LD;
				end
				S_MEAN_LD: begin
					div_num_q <= div_t'(sum_q) * div_t'(MEAN_SCALE) + div_t'(count_q >> 1);
					div_rem_q <= '0;
					div_cnt_q <= 5'(DIV_W - 1);
					div_sel_q <= 1'b0;
					state_q   <= S_DIV;
				end
				S_PASS_LD: begin
					div_num_q <= div_t'(passed_q) * div_t'(PASS_SCALE) + div_t'(count_q >> 1);
					div_rem_q <= '0;
					div_cnt_q <= 5'(DIV_W - 1);
					div_sel_q <= 1'b1;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_num_q <= num_nx;
					div_rem_q <= rem_nx;
					div_cnt_q <= 5'(div_cnt_q - 5'd1);
					if (div_cnt_q == '0) begin
						if (div_sel_q) begin
							res_pass_q <= num_nx[13:0];
							state_q    <= S_FIN;
						end else begin
							res_mean_q <= num_nx[16:0];
							state_q    <= S_PASS_LD;
						end
					end
				end
				S_FIN: begin
					done_q    <= 1'b1;
					status_q  <= res_status_q;
					total_q   <= count_q;
					min_q     <= lo_q;
					max_q     <= hi_q;
					mean_q    <= res_mean_q;
					median_q  <= res_median_q;
					pass_q    <= res_pass_q;
					bin_cnt_q <= res_bin_q;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign sample_total = total_q;
	assign min_value    = min_q;
	assign max_value    = max_q;
	assign mean_milli   = mean_q;
	assign median_value = median_q;
	assign pass_centi   = pass_q;
	assign bin_count    = bin_cnt_q;

endmodule
